/* design/dfpd_pkg.sv */
// ----------------------------------------------------------------------------
// dfpd_pkg
// Shared types, widths and constant tables for the decimal fixed-point divider.
// ----------------------------------------------------------------------------
package dfpd_pkg;

    // Default number of fractional decimal digits.
    localparam int FRACTION_DIGITS_DEF = 6;

    // The dividend is scaled up until it reaches this value.
    localparam logic [63:0] DIVIDEND_TARGET = 64'd10000000000000;
    // Number of times ten is applied at most to reach the target.
    localparam int          SCALE_STEPS     = 13;

    // Largest positive magnitude.
    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // Width of a scaled divisor, enough for ten to the largest digit count.
    localparam int VBS_W = 30;

    // Number of divisor compare thresholds.
    localparam int THR_N = 19;

    typedef logic [0:31][63:0]       t_pow_tab;
    typedef logic [0:15][63:0]       t_max_tab;
    typedef logic [0:THR_N-1][127:0] t_thr_tab;

    // Input beat.
    typedef struct packed {
        logic signed [63:0] dividend;
        logic signed [63:0] divisor;
    } t_in;

    // Output beat.
    typedef struct packed {
        logic signed [63:0] quotient;
        logic               divide_by_zero;
        logic               overflowed;
    } t_out;

    // Side data carried through the divisor scaling divider.
    typedef struct packed {
        logic [63:0] va;
        logic [3:0]  sa;
        logic [5:0]  shift;
        logic        neg;
        logic        za;
        logic        zb;
    } t_sb1;

    // Side data carried through the magnitude divider.
    typedef struct packed {
        logic [5:0] shift;
        logic       neg;
        logic       za;
        logic       zb;
    } t_sb2;

    // Side data carried through the rescaling divider.
    typedef struct packed {
        logic [3:0] mup;
        logic       neg;
        logic       za;
        logic       zb;
    } t_sb3;

    // Powers of ten; entries past ten to the nineteenth are never selected.
    function automatic t_pow_tab pow10_tab();
        t_pow_tab    tab;
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < 32; i++) begin
            tab[i] = p;
            p      = p * 64'd10;
        end
        return tab;
    endfunction

    localparam t_pow_tab POW10 = pow10_tab();

    // Largest value that may be scaled up by ten to the m without overflow.
    function automatic t_max_tab max_tab();
        t_max_tab tab;
        for (int m = 0; m < 16; m++) begin
            tab[m] = MAG_MAX / POW10[m];
        end
        return tab;
    endfunction

    localparam t_max_tab MAXDIV = max_tab();

    // Divisor thresholds: the divisor takes more than t divides by ten
    // exactly when it is at least (10^fd + 1) * 10^t.
    function automatic t_thr_tab div_thr(int fd);
        t_thr_tab     tab;
        logic [127:0] p;
        p = 128'd1;
        for (int i = 0; i < fd; i++) begin
            p = p * 128'd10;
        end
        p = p + 128'd1;
        for (int t = 0; t < THR_N; t++) begin
            tab[t] = p;
            p      = p * 128'd10;
        end
        return tab;
    endfunction

endpackage

/* design/dfpd_div_pipe.sv */
// ----------------------------------------------------------------------------
// dfpd_div_pipe
// Unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module dfpd_div_pipe #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 64,
    parameter int SB_W  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output logic [SB_W-1:0]  o_sb
);

    logic             r_v   [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_qd  [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [SB_W-1:0]  r_sb  [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic             w_v;
        logic [DEN_W-1:0] w_rem;
        logic [NUM_W-1:0] w_qd;
        logic [DEN_W-1:0] w_den;
        logic [SB_W-1:0]  w_sb;
        logic [DEN_W:0]   w_try;
        logic             w_ge;

        // Stage inputs come from the ports or from the previous stage.
        if (s == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_rem = '0;
            assign w_qd  = i_num;
            assign w_den = i_den;
            assign w_sb  = i_sb;
        end else begin : g_next
            assign w_v   = r_v[s-1];
            assign w_rem = r_rem[s-1];
            assign w_qd  = r_qd[s-1];
            assign w_den = r_den[s-1];
            assign w_sb  = r_sb[s-1];
        end

        // Bring down the next dividend bit and try the subtraction.
        assign w_try = {w_rem, w_qd[NUM_W-1]};
        assign w_ge  = (w_try >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? DEN_W'(w_try - {1'b0, w_den}) : w_try[DEN_W-1:0];
                r_qd[s]  <= {w_qd[NUM_W-2:0], w_ge};
                r_den[s] <= w_den;
                r_sb[s]  <= w_sb;
            end
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quo   = r_qd[NUM_W-1];
    assign o_sb    = r_sb[NUM_W-1];

endmodule

/* design/dfpd_front.sv */
// ----------------------------------------------------------------------------
// dfpd_front
// Input stage: magnitudes, sign, zero tests and decimal shift counts.
// ----------------------------------------------------------------------------
module dfpd_front import dfpd_pkg::*; #(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_in         i_data,
    output logic        o_valid,
    output logic [63:0] o_num,
    output logic [63:0] o_den,
    output t_sb1        o_sb
);

    localparam t_thr_tab THR = div_thr(FRACTION_DIGITS);

    logic [63:0]          w_va;
    logic [63:0]          w_vb;
    logic [SCALE_STEPS-1:0] w_below;
    logic [THR_N-1:0]     w_above;
    logic [3:0]           w_sa;
    logic [4:0]           w_k;
    t_sb1                 w_sb;

    logic                 r_v;
    logic [63:0]          r_num;
    logic [63:0]          r_den;
    t_sb1                 r_sb;

    // Two's complement magnitudes; the most negative value gives 2^63.
    assign w_va = i_data.dividend[63] ? (~i_data.dividend + 64'd1) : i_data.dividend;
    assign w_vb = i_data.divisor[63]  ? (~i_data.divisor + 64'd1)  : i_data.divisor;

    // Count the powers of ten the dividend stays below, and the divisor
    // thresholds it reaches; each count is the number of scaling steps.
    always_comb begin
        for (int t = 0; t < SCALE_STEPS; t++) begin
            w_below[t] = (w_va < POW10[t+1]);
        end
        for (int t = 0; t < THR_N; t++) begin
            w_above[t] = ({64'd0, w_vb} >= THR[t]);
        end
    end

    assign w_sa = 4'($countones(w_below));
    assign w_k  = 5'($countones(w_above));

    always_comb begin
        w_sb.va    = w_va;
        w_sb.sa    = w_sa;
        w_sb.shift = 6'(w_sa) + 6'(w_k);
        w_sb.neg   = i_data.dividend[63] ^ i_data.divisor[63];
        w_sb.za    = (w_va == 64'd0);
        w_sb.zb    = (w_vb == 64'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= w_vb;
            r_den <= POW10[w_k];
            r_sb  <= w_sb;
        end
    end

    assign o_valid = r_v;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_sb    = r_sb;

endmodule

/* design/dfpd_scale.sv */
// ----------------------------------------------------------------------------
// dfpd_scale
// Dividend scaling chain: one conditional multiply by ten per stage.
// ----------------------------------------------------------------------------
module dfpd_scale import dfpd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_sb1             i_sb,
    input  logic [VBS_W-1:0] i_vbs,
    output logic             o_valid,
    output logic [63:0]      o_num,
    output logic [VBS_W-1:0] o_den,
    output t_sb2             o_sb
);

    logic             r_v   [SCALE_STEPS];
    logic [63:0]      r_x   [SCALE_STEPS];
    t_sb1             r_sb  [SCALE_STEPS];
    logic [VBS_W-1:0] r_vbs [SCALE_STEPS];

    for (genvar j = 0; j < SCALE_STEPS; j++) begin : g_stage
        logic             w_v;
        logic [63:0]      w_x;
        t_sb1             w_sb;
        logic [VBS_W-1:0] w_vbs;

        if (j == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_x   = i_sb.va;
            assign w_sb  = i_sb;
            assign w_vbs = i_vbs;
        end else begin : g_next
            assign w_v   = r_v[j-1];
            assign w_x   = r_x[j-1];
            assign w_sb  = r_sb[j-1];
            assign w_vbs = r_vbs[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= w_v;
            end
        end

        // Times ten as eight times plus two times.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j]   <= (4'(j) < w_sb.sa) ? ({w_x[60:0], 3'b000} + {w_x[62:0], 1'b0})
                                               : w_x;
                r_sb[j]  <= w_sb;
                r_vbs[j] <= w_vbs;
            end
        end
    end

    assign o_valid  = r_v[SCALE_STEPS-1];
    assign o_num    = r_x[SCALE_STEPS-1];
    assign o_den    = r_vbs[SCALE_STEPS-1];
    assign o_sb.shift = r_sb[SCALE_STEPS-1].shift;
    assign o_sb.neg   = r_sb[SCALE_STEPS-1].neg;
    assign o_sb.za    = r_sb[SCALE_STEPS-1].za;
    assign o_sb.zb    = r_sb[SCALE_STEPS-1].zb;

endmodule

/* design/dfpd_post.sv */
// ----------------------------------------------------------------------------
// dfpd_post
// Upward rescaling with saturation, sign and the output register.
// ----------------------------------------------------------------------------
module dfpd_post import dfpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_q,
    input  t_sb3        i_sb,
    output logic        o_valid,
    output t_out        o_data
);

    logic [31:0] w_p;

    logic        r_va;
    logic [63:0] r_lo;
    logic [63:0] r_hi;
    logic        r_sat_a;
    t_sb3        r_sb_a;

    logic        r_vb;
    logic [63:0] r_mag;
    logic        r_sat_b;
    t_sb3        r_sb_b;

    logic        r_vc;
    t_out        r_out;

    assign w_p = POW10[5'(i_sb.mup)][31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    // Stage A: split product and overflow test against the scaled limit.
    // Stage B: sum the halves or saturate. Stage C: sign and flags.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo    <= 64'(i_q[31:0]) * 64'(w_p);
            r_hi    <= 64'(i_q[63:32]) * 64'(w_p);
            r_sat_a <= (i_q > MAXDIV[i_sb.mup]);
            r_sb_a  <= i_sb;

            r_mag   <= r_sat_a ? MAG_MAX : (r_lo + {r_hi[31:0], 32'd0});
            r_sat_b <= r_sat_a;
            r_sb_b  <= r_sb_a;

            if (r_sb_b.za || r_sb_b.zb) begin
                r_out.quotient <= '0;
                r_out.overflowed <= 1'b0;
            end else begin
                r_out.quotient <= r_sb_b.neg ? (~r_mag + 64'd1) : r_mag;
                r_out.overflowed <= r_sat_b;
            end
            r_out.divide_by_zero <= r_sb_b.zb & ~r_sb_b.za;
        end
    end

    assign o_valid = r_vc;
    assign o_data  = r_out;

endmodule

/* design/decimal_fixed_point_divide.sv */
// ----------------------------------------------------------------------------
// decimal_fixed_point_divide
// Signed decimal fixed-point divider, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: operand beats enter on i_valid/o_ready carrying i_data (dividend and
// divisor, each the value times ten to FRACTION_DIGITS). Result beats leave on
// o_valid/i_ready carrying o_data: quotient truncated toward zero, a divide by
// zero flag and a saturation flag.
// The pipeline holds one input stage, a 64-stage divider that scales the
// divisor, 13 dividend scaling stages, a 64-stage divider for the magnitudes,
// a 64-stage divider for downward rescaling and three output stages.
// Throughput is one beat per cycle while i_ready does not stall the output;
// the one-bit-per-stage dividers set the depth, not the rate.
// The whole pipeline advances together: while a result waits at the output
// and i_ready is low, o_ready is low and nothing moves, so no beat is lost.
// Synchronous reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module decimal_fixed_point_divide import dfpd_pkg::*; #(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam logic [5:0] FD6 = 6'(FRACTION_DIGITS);

    logic        w_en;

    logic        w_f_v;
    logic [63:0] w_f_num;
    logic [63:0] w_f_den;
    t_sb1        w_f_sb;

    logic        w_d1_v;
    logic [63:0] w_d1_quo;
    t_sb1        w_d1_sb;

    logic             w_s_v;
    logic [63:0]      w_s_num;
    logic [VBS_W-1:0] w_s_den;
    t_sb2             w_s_sb;

    logic        w_d2_v;
    logic [63:0] w_d2_quo;
    t_sb2        w_d2_sb;

    logic [5:0]  w_diff;
    logic [4:0]  w_mdn;
    t_sb3        w_sb3;

    logic        w_d3_v;
    logic [63:0] w_d3_quo;
    t_sb3        w_d3_sb;

    // Every stage moves when the output register is free or being taken.
    assign w_en    = ~o_valid | i_ready;
    assign o_ready = w_en;

    dfpd_front #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(i_valid), .i_data(i_data),
        .o_valid(w_f_v), .o_num(w_f_num), .o_den(w_f_den), .o_sb(w_f_sb)
    );

    // Divisor magnitude divided by ten to the divisor shift count.
    dfpd_div_pipe #(.NUM_W(64), .DEN_W(64), .SB_W($bits(t_sb1))) u_div_scale (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_f_v), .i_num(w_f_num), .i_den(w_f_den), .i_sb(w_f_sb),
        .o_valid(w_d1_v), .o_quo(w_d1_quo), .o_sb(w_d1_sb)
    );

    dfpd_scale u_scale (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_d1_v), .i_sb(w_d1_sb), .i_vbs(w_d1_quo[VBS_W-1:0]),
        .o_valid(w_s_v), .o_num(w_s_num), .o_den(w_s_den), .o_sb(w_s_sb)
    );

    // Integer quotient of the scaled magnitudes.
    dfpd_div_pipe #(.NUM_W(64), .DEN_W(VBS_W), .SB_W($bits(t_sb2))) u_div_mag (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_s_v), .i_num(w_s_num), .i_den(w_s_den), .i_sb(w_s_sb),
        .o_valid(w_d2_v), .o_quo(w_d2_quo), .o_sb(w_d2_sb)
    );

    // Rescale direction: a surplus shift divides, a shortfall multiplies.
    // Ten to the nineteenth already exceeds any quotient, so it caps the divide.
    assign w_diff = w_d2_sb.shift - FD6;

    always_comb begin
        w_mdn     = '0;
        w_sb3.mup = '0;
        if (w_d2_sb.shift > FD6) begin
            w_mdn = (w_diff > 6'd19) ? 5'd19 : w_diff[4:0];
        end else begin
            w_sb3.mup = 4'(FD6 - w_d2_sb.shift);
        end
        w_sb3.neg = w_d2_sb.neg;
        w_sb3.za  = w_d2_sb.za;
        w_sb3.zb  = w_d2_sb.zb;
    end

    dfpd_div_pipe #(.NUM_W(64), .DEN_W(64), .SB_W($bits(t_sb3))) u_div_rescale (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_d2_v), .i_num(w_d2_quo), .i_den(POW10[w_mdn]), .i_sb(w_sb3),
        .o_valid(w_d3_v), .o_quo(w_d3_quo), .o_sb(w_d3_sb)
    );

    dfpd_post u_post (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_d3_v), .i_q(w_d3_quo), .i_sb(w_d3_sb),
        .o_valid(o_valid), .o_data(o_data)
    );

endmodule

/* tb/dfpd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfpd_checker
// Watches both channels of the decimal divider, predicts every result beat
// from the accepted operand beats and compares them field by field.
// ----------------------------------------------------------------------------
module dfpd_checker import dfpd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_errors,
    output int   o_pending
);

    localparam int FD = FRACTION_DIGITS_DEF;

    t_out quotients_due[$];

    // Magnitude of a two's complement value; the most negative gives 2^63.
    function automatic logic [63:0] abs_of(logic [63:0] raw);
        return raw[63] ? (~raw) + 64'd1 : raw;
    endfunction

    // Scale, divide and rescale as the decimal divider does.
    function automatic t_out divide_decimal(t_in op);
        t_out        res;
        logic [63:0] va;
        logic [63:0] vb;
        logic [63:0] lim;
        logic [63:0] q;
        int          shift;
        logic        sat;
        va    = abs_of(op.dividend);
        vb    = abs_of(op.divisor);
        lim   = 64'd1;
        shift = 0;
        sat   = 1'b0;
        res   = '0;
        for (int i = 0; i < FD; i++) lim = lim * 64'd10;
        if (va == 64'd0) return res;
        if (vb == 64'd0) begin
            res.divide_by_zero = 1'b1;
            return res;
        end
        while (va < DIVIDEND_TARGET) begin
            va = va * 64'd10;
            shift++;
        end
        while (vb > lim) begin
            vb = vb / 64'd10;
            shift++;
        end
        q = va / vb;
        while (shift > FD) begin
            q = q / 64'd10;
            shift--;
        end
        while (shift < FD && !sat) begin
            if (q > MAG_MAX / 64'd10) begin
                sat = 1'b1;
            end else begin
                q = q * 64'd10;
                shift++;
            end
        end
        if (q > MAG_MAX) sat = 1'b1;
        if (sat) q = MAG_MAX;
        if (op.dividend[63] != op.divisor[63]) q = (~q) + 64'd1;
        res.quotient   = q;
        res.overflowed = sat;
        return res;
    endfunction

    // Predict on operand beats, compare on result beats.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) quotients_due.push_back(divide_decimal(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (quotients_due.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = quotients_due.pop_front();
                    if (want.quotient !== i_out_data.quotient ||
                            want.divide_by_zero !== i_out_data.divide_by_zero ||
                            want.overflowed !== i_out_data.overflowed) begin
                        $display("%0t: mismatch expected q=%0d dz=%b ov=%b actual q=%0d dz=%b ov=%b",
                            $time, want.quotient, want.divide_by_zero, want.overflowed,
                            i_out_data.quotient, i_out_data.divide_by_zero,
                            i_out_data.overflowed);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= quotients_due.size();
        end
    end

endmodule

/* tb/tb_decimal_fixed_point_divide.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_decimal_fixed_point_divide
// Drives directed and random operand beats into the decimal divider under
// varying idle patterns on both sides and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_decimal_fixed_point_divide;
    import dfpd_pkg::*;

    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;
    int   errors;
    int   pending;
    int   rx_idle_pct;

    decimal_fixed_point_divide u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    dfpd_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_out_data  (o_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Clock with an 8 ns period.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Receiver stalls at random on falling edges.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Random 64-bit operand, often a small or scaled value.
    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        case ($urandom_range(5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(2000000));
            2: v = {32'd0, $urandom};
            3: v = {$urandom, $urandom} >> $urandom_range(63);
            4: v = 64'($urandom_range(3));
            default: v = {$urandom, $urandom} >> 20;
        endcase
        if ($urandom_range(1)) v = (~v) + 64'd1;
        return v;
    endfunction

    // Present one operand beat and hold it until accepted; the sender drops
    // valid only while it idles, so back-to-back beats keep it high.
    task automatic send_operands(logic [63:0] a, logic [63:0] b, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data.dividend <= a;
        i_data.divisor  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        logic [63:0] dir_ops[12];
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_ready     = 1'b0;
        rx_idle_pct = 0;
        dir_ops = '{64'd0, 64'd1, 64'd1000000, 64'd1000001, MAG_MAX, MOST_NEG,
                    64'hFFFF_FFFF_FFFF_FFFF, 64'd10000000000000, 64'd9999999,
                    64'd7, 64'hFFFF_FFFF_FFF0_BDC0, 64'd123456789};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corners: zeros, extremes, signs and saturation.
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++)
                send_operands(dir_ops[i * 2 + (j & 1)], dir_ops[(j * 3 + i) % 12], 0);

        // Random phases with changing idle patterns.
        for (int ph = 0; ph < 3; ph++) begin
            int tx_idle;
            tx_idle     = (ph == 0) ? 19 : (ph == 1) ? 86 : 0;
            rx_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 19 : 0;
            for (int n = 0; n < 415; n++) begin
                send_operands(rand_operand(), rand_operand(), tx_idle);
                // Hold off once per phase until the pipeline drains.
                if (n == 200) begin
                    i_valid <= 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
            end
        end

        i_valid     <= 1'b0;
        rx_idle_pct = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (250) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Global watchdog.
    initial begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
